// ===== rtl/rmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types for the rotation matrix to quaternion core.
// ----------------------------------------------------------------------------
package rmq_pkg;

   typedef enum logic [1:0] {
      PICK_W = 2'd0,
      PICK_X = 2'd1,
      PICK_Y = 2'd2,
      PICK_Z = 2'd3
   } pick_type;

   // per-cycle control shared by every pipeline stage
   typedef struct packed {
      logic advance;
   } stage_ctrl_type;

endpackage

// ===== rtl/rmq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_req_if / rmq_rsp_if
// Valid/ready channels for matrix beats and quaternion beats.
// ----------------------------------------------------------------------------
interface rmq_req_if #(parameter int DATA_WIDTH = 16) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] col0_row0;
   logic signed [DATA_WIDTH-1:0] col0_row1;
   logic signed [DATA_WIDTH-1:0] col0_row2;
   logic signed [DATA_WIDTH-1:0] col1_row0;
   logic signed [DATA_WIDTH-1:0] col1_row1;
   logic signed [DATA_WIDTH-1:0] col1_row2;
   logic signed [DATA_WIDTH-1:0] col2_row0;
   logic signed [DATA_WIDTH-1:0] col2_row1;
   logic signed [DATA_WIDTH-1:0] col2_row2;

   modport source (output valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
                   col1_row2, col2_row0, col2_row1, col2_row2, input ready);
   modport sink (input valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
                 col1_row2, col2_row0, col2_row1, col2_row2, output ready);
endinterface

interface rmq_rsp_if #(parameter int DATA_WIDTH = 16) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] quat_w;
   logic signed [DATA_WIDTH-1:0] quat_x;
   logic signed [DATA_WIDTH-1:0] quat_y;
   logic signed [DATA_WIDTH-1:0] quat_z;
   logic [1:0]                   largest_pick;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, largest_pick, input ready);
   modport sink (input valid, quat_w, quat_x, quat_y, quat_z, largest_pick, output ready);
endinterface

// ===== rtl/rmq_div_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div_lane
// Pipelined restoring divider: (mag * 2^F + s) / (2 * s), one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module rmq_div_lane
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 14,
   parameter int ROOT_WIDTH = 16
) (
   input  logic                  clock,
   input  stage_ctrl_type        ctrl,
   input  logic [DATA_WIDTH:0]   mag,
   input  logic                  neg,
   input  logic [ROOT_WIDTH-1:0] root,
   output logic [DATA_WIDTH:0]   quo,
   output logic                  quo_neg
);
   localparam int MW = DATA_WIDTH + 1;
   localparam int QW = DATA_WIDTH + 1;
   localparam int NA = ((MW + FRAC_BITS) > ROOT_WIDTH) ? (MW + FRAC_BITS) : ROOT_WIDTH;
   localparam int NN = NA + 1;
   localparam int CW = (NN > (ROOT_WIDTH + 1 + QW)) ? NN : (ROOT_WIDTH + 1 + QW);

   logic [CW-1:0]         rem_ff [QW];
   logic [CW-1:0]         rem_in [QW];
   logic [QW-1:0]         q_ff   [QW];
   logic [QW-1:0]         q_in   [QW];
   logic [ROOT_WIDTH:0]   den_ff [QW];
   logic [ROOT_WIDTH:0]   den_in [QW];
   logic                  neg_ff [QW];
   logic                  neg_in [QW];
   logic [CW-1:0]         rem_src;
   logic [QW-1:0]         q_src;
   logic [CW-1:0]         dsh;

   always_comb begin
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            rem_src   = {{(CW - MW - FRAC_BITS){1'b0}}, mag, {FRAC_BITS{1'b0}}}
                        + {{(CW - ROOT_WIDTH){1'b0}}, root};
            q_src     = '0;
            den_in[k] = {root, 1'b0};
            neg_in[k] = neg;
         end else begin
            rem_src   = rem_ff[k-1];
            q_src     = q_ff[k-1];
            den_in[k] = den_ff[k-1];
            neg_in[k] = neg_ff[k-1];
         end
         dsh = {{(CW - ROOT_WIDTH - 1){1'b0}}, den_in[k]} << (QW - 1 - k);
         if (rem_src >= dsh) begin
            rem_in[k] = rem_src - dsh;
            q_in[k]   = q_src | (QW'(1) << (QW - 1 - k));
         end else begin
            rem_in[k] = rem_src;
            q_in[k]   = q_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         for (int k = 0; k < QW; k++) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            den_ff[k] <= den_in[k];
            neg_ff[k] <= neg_in[k];
         end
      end
   end

   assign quo     = q_ff[QW-1];
   assign quo_neg = neg_ff[QW-1];
endmodule

// ===== rtl/rotation_matrix_to_quaternion_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Shepperd conversion of a 3x3 rotation matrix to a unit quaternion.
// ----------------------------------------------------------------------------
// Stages: input register, pick stage, one square root bit per stage, one
// quotient bit per stage, output register.
// Throughput: one matrix per cycle; the whole pipeline holds while the
// output beat is not taken.
// Reset: synchronous, clears every stage valid bit.
module rotation_matrix_to_quaternion_core
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic     clock,
   input  logic     reset,
   rmq_req_if.sink  req_ch,
   rmq_rsp_if.source rsp_ch
);
   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int VW = W + 2;
   localparam int NB = VW + F;
   localparam int NE = NB + (NB % 2);
   localparam int SB = NE / 2;
   localparam int QW = W + 1;
   localparam int XW = (SB > QW) ? SB : QW;

   localparam logic [XW-1:0] SMAX_X = {{(XW - W + 1){1'b0}}, {(W - 1){1'b1}}};
   localparam logic [XW-1:0] HALF_X = {{(XW - W){1'b0}}, 1'b1, {(W - 1){1'b0}}};

   function automatic logic [W-1:0] sat_mag(input logic [XW-1:0] m, input logic n);
      logic [W-1:0] r;
      if (!n) begin
         r = (m > SMAX_X) ? {1'b0, {(W - 1){1'b1}}} : m[W-1:0];
      end else begin
         r = (m > HALF_X) ? {1'b1, {(W - 1){1'b0}}} : (W'(0) - m[W-1:0]);
      end
      return r;
   endfunction

   stage_ctrl_type ctrl;
   logic           out_valid_ff;

   assign ctrl.advance = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = ctrl.advance;

   // ---------------- input register
   logic                a_valid_ff;
   logic signed [W-1:0] m00_ff, m01_ff, m02_ff, m10_ff, m11_ff, m12_ff, m20_ff, m21_ff, m22_ff;

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         m00_ff <= req_ch.col0_row0;
         m01_ff <= req_ch.col0_row1;
         m02_ff <= req_ch.col0_row2;
         m10_ff <= req_ch.col1_row0;
         m11_ff <= req_ch.col1_row1;
         m12_ff <= req_ch.col1_row2;
         m20_ff <= req_ch.col2_row0;
         m21_ff <= req_ch.col2_row1;
         m22_ff <= req_ch.col2_row2;
      end
   end

   // ---------------- pick stage
   logic signed [VW-1:0] v0, v1, v2, v3, best;
   logic signed [W:0]    a00, a11, a22;
   logic signed [W:0]    da, db, dc;
   logic [VW-1:0]        t_val;
   pick_type             pick_in;

   always_comb begin
      a00 = {m00_ff[W-1], m00_ff};
      a11 = {m11_ff[W-1], m11_ff};
      a22 = {m22_ff[W-1], m22_ff};
      v0  = VW'(a00) + VW'(a11) + VW'(a22);
      v1  = VW'(a00) - VW'(a11) - VW'(a22);
      v2  = VW'(a11) - VW'(a00) - VW'(a22);
      v3  = VW'(a22) - VW'(a00) - VW'(a11);
      best    = v0;
      pick_in = PICK_W;
      if (v1 > best) begin
         best    = v1;
         pick_in = PICK_X;
      end
      if (v2 > best) begin
         best    = v2;
         pick_in = PICK_Y;
      end
      if (v3 > best) begin
         best    = v3;
         pick_in = PICK_Z;
      end
      t_val = best + (VW'(1) << F);
      unique case (pick_in)
         PICK_W: begin
            da = (W+1)'(m12_ff) - (W+1)'(m21_ff);
            db = (W+1)'(m20_ff) - (W+1)'(m02_ff);
            dc = (W+1)'(m01_ff) - (W+1)'(m10_ff);
         end
         PICK_X: begin
            da = (W+1)'(m12_ff) - (W+1)'(m21_ff);
            db = (W+1)'(m01_ff) + (W+1)'(m10_ff);
            dc = (W+1)'(m20_ff) + (W+1)'(m02_ff);
         end
         PICK_Y: begin
            da = (W+1)'(m20_ff) - (W+1)'(m02_ff);
            db = (W+1)'(m01_ff) + (W+1)'(m10_ff);
            dc = (W+1)'(m12_ff) + (W+1)'(m21_ff);
         end
         default: begin
            da = (W+1)'(m01_ff) - (W+1)'(m10_ff);
            db = (W+1)'(m20_ff) + (W+1)'(m02_ff);
            dc = (W+1)'(m12_ff) + (W+1)'(m21_ff);
         end
      endcase
   end

   logic          b_valid_ff;
   pick_type      b_pick_ff;
   logic [NE-1:0] b_n_ff;
   logic [W:0]    b_mag_ff [3];
   logic          b_neg_ff [3];

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         b_pick_ff   <= pick_in;
         b_n_ff      <= {{(NE - NB){1'b0}}, t_val, {F{1'b0}}};
         b_neg_ff[0] <= da[W];
         b_neg_ff[1] <= db[W];
         b_neg_ff[2] <= dc[W];
         b_mag_ff[0] <= da[W] ? ((W+1)'(0) - da) : da;
         b_mag_ff[1] <= db[W] ? ((W+1)'(0) - db) : db;
         b_mag_ff[2] <= dc[W] ? ((W+1)'(0) - dc) : dc;
      end
   end

   // ---------------- square root, one result bit per stage
   logic          sq_valid_ff [SB];
   pick_type      sq_pick_ff  [SB];
   logic [NE-1:0] sq_n_ff     [SB];
   logic [NE-1:0] sq_r_ff     [SB];
   logic [NE-1:0] sq_n_in     [SB];
   logic [NE-1:0] sq_r_in     [SB];
   logic [W:0]    sq_mag_ff   [SB][3];
   logic          sq_neg_ff   [SB][3];
   logic [NE-1:0] n_src, r_src, bitv;

   always_comb begin
      for (int k = 0; k < SB; k++) begin
         n_src = (k == 0) ? b_n_ff : sq_n_ff[(k == 0) ? 0 : k - 1];
         r_src = (k == 0) ? '0 : sq_r_ff[(k == 0) ? 0 : k - 1];
         bitv  = NE'(1) << (NE - 2 - 2 * k);
         if (n_src >= r_src + bitv) begin
            sq_n_in[k] = n_src - (r_src + bitv);
            sq_r_in[k] = (r_src >> 1) + bitv;
         end else begin
            sq_n_in[k] = n_src;
            sq_r_in[k] = r_src >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         for (int k = 0; k < SB; k++) begin
            sq_n_ff[k] <= sq_n_in[k];
            sq_r_ff[k] <= sq_r_in[k];
            if (k == 0) begin
               sq_pick_ff[k] <= b_pick_ff;
               for (int l = 0; l < 3; l++) begin
                  sq_mag_ff[k][l] <= b_mag_ff[l];
                  sq_neg_ff[k][l] <= b_neg_ff[l];
               end
            end else begin
               sq_pick_ff[k] <= sq_pick_ff[k-1];
               for (int l = 0; l < 3; l++) begin
                  sq_mag_ff[k][l] <= sq_mag_ff[k-1][l];
                  sq_neg_ff[k][l] <= sq_neg_ff[k-1][l];
               end
            end
         end
      end
   end

   // ---------------- dividers
   logic [SB-1:0] root;
   logic [SB:0]   root_inc;
   logic [SB-1:0] big;
   logic [W:0]    quo     [3];
   logic          quo_neg [3];

   assign root     = sq_r_ff[SB-1][SB-1:0];
   assign root_inc = {1'b0, root} + (SB+1)'(1);
   assign big      = root_inc[SB:1];

   for (genvar l = 0; l < 3; l++) begin : g_lane
      rmq_div_lane #(
         .DATA_WIDTH (W),
         .FRAC_BITS  (F),
         .ROOT_WIDTH (SB)
      ) u_lane (
         .clock   (clock),
         .ctrl    (ctrl),
         .mag     (sq_mag_ff[SB-1][l]),
         .neg     (sq_neg_ff[SB-1][l]),
         .root    (root),
         .quo     (quo[l]),
         .quo_neg (quo_neg[l])
      );
   end

   logic          dv_valid_ff [QW];
   pick_type      dv_pick_ff  [QW];
   logic [SB-1:0] dv_big_ff   [QW];

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
               dv_pick_ff[k] <= sq_pick_ff[SB-1];
               dv_big_ff[k]  <= big;
            end else begin
               dv_pick_ff[k] <= dv_pick_ff[k-1];
               dv_big_ff[k]  <= dv_big_ff[k-1];
            end
         end
      end
   end

   // ---------------- output register
   logic [W-1:0] sat_a, sat_b, sat_c, sat_big;
   logic [W-1:0] qw_in, qx_in, qy_in, qz_in;
   logic [W-1:0] qw_ff, qx_ff, qy_ff, qz_ff;
   pick_type     out_pick_ff;

   always_comb begin
      sat_a   = sat_mag(XW'(quo[0]), quo_neg[0]);
      sat_b   = sat_mag(XW'(quo[1]), quo_neg[1]);
      sat_c   = sat_mag(XW'(quo[2]), quo_neg[2]);
      sat_big = sat_mag(XW'(dv_big_ff[QW-1]), 1'b0);
      unique case (dv_pick_ff[QW-1])
         PICK_W: begin
            qw_in = sat_big; qx_in = sat_a; qy_in = sat_b; qz_in = sat_c;
         end
         PICK_X: begin
            qw_in = sat_a; qx_in = sat_big; qy_in = sat_b; qz_in = sat_c;
         end
         PICK_Y: begin
            qw_in = sat_a; qx_in = sat_b; qy_in = sat_big; qz_in = sat_c;
         end
         default: begin
            qw_in = sat_a; qx_in = sat_b; qy_in = sat_c; qz_in = sat_big;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         qw_ff       <= qw_in;
         qx_ff       <= qx_in;
         qy_ff       <= qy_in;
         qz_ff       <= qz_in;
         out_pick_ff <= dv_pick_ff[QW-1];
      end
   end

   // ---------------- valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < SB; k++) sq_valid_ff[k] <= 1'b0;
         for (int k = 0; k < QW; k++) dv_valid_ff[k] <= 1'b0;
      end else if (ctrl.advance) begin
         a_valid_ff <= req_ch.valid;
         b_valid_ff <= a_valid_ff;
         for (int k = 0; k < SB; k++) begin
            sq_valid_ff[k] <= (k == 0) ? b_valid_ff : sq_valid_ff[(k == 0) ? 0 : k - 1];
         end
         for (int k = 0; k < QW; k++) begin
            dv_valid_ff[k] <= (k == 0) ? sq_valid_ff[SB-1] : dv_valid_ff[(k == 0) ? 0 : k - 1];
         end
         out_valid_ff <= dv_valid_ff[QW-1];
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.quat_w       = qw_ff;
   assign rsp_ch.quat_x       = qx_ff;
   assign rsp_ch.quat_y       = qy_ff;
   assign rsp_ch.quat_z       = qz_ff;
   assign rsp_ch.largest_pick = out_pick_ff;
endmodule

// ===== tb/tb_rotation_matrix_to_quaternion_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_core
// Drives matrix beats with random gaps and random output stalls. Each
// quaternion beat is checked against an in-bench Shepperd predictor; a
// directed table covers the identity, half-turns, ties and saturating cases.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion_core;
   import rmq_pkg::*;

   localparam int DW         = 16;
   localparam int FB         = 14;
   localparam int ONE        = 1 << FB;
   localparam int N_RANDOM   = 1930;
   localparam int WDOG_LIMIT = 20000;
   localparam int DRAIN      = 80;

   typedef logic signed [DW-1:0] elem_type;

   typedef struct {
      elem_type m [9];   // column-major: index c*3+r
   } matrix_type;

   typedef struct {
      elem_type w, x, y, z;
      pick_type pick;
   } quat_type;

   typedef struct {
      matrix_type mat;
      bit         fixed;
      quat_type   q;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmq_req_if #(.DATA_WIDTH(DW)) req_ch ();
   rmq_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

   rotation_matrix_to_quaternion_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   quat_type quat_pending [$];
   int       n_fail = 0;
   int       n_sent = 0;
   int       n_recv = 0;
   int       idle_cycles = 0;
   int       pick_seen [4] = '{0, 0, 0, 0};
   bit       stim_done = 1'b0;
   row_type  directed [$];

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic elem_type clamp(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return elem_type'(v);
   endfunction

   // d * 2^FB / (2s), rounded half away from zero
   function automatic elem_type part_over_root(longint d, longint unsigned s);
      longint unsigned mag, quo;
      mag = (d < 0) ? longint'(-d) : d;
      quo = ((mag << FB) + s) / (2 * s);
      return clamp((d < 0) ? -longint'(quo) : longint'(quo));
   endfunction

   function automatic quat_type shepperd(matrix_type mt);
      longint m [3][3];
      longint v [4];
      longint unsigned s;
      longint big;
      int pk;
      quat_type q;
      for (int c = 0; c < 3; c++)
         for (int r = 0; r < 3; r++)
            m[c][r] = mt.m[c*3+r];
      v[0] = m[0][0] + m[1][1] + m[2][2];
      v[1] = m[0][0] - m[1][1] - m[2][2];
      v[2] = m[1][1] - m[0][0] - m[2][2];
      v[3] = m[2][2] - m[0][0] - m[1][1];
      pk = 0;
      for (int k = 1; k < 4; k++)
         if (v[k] > v[pk]) pk = k;
      s = int_sqrt(longint'(v[pk] + ONE) << FB);
      big = (s + 1) >> 1;
      q.pick = pick_type'(pk);
      case (q.pick)
         PICK_W: begin
            q.w = clamp(big);
            q.x = part_over_root(m[1][2] - m[2][1], s);
            q.y = part_over_root(m[2][0] - m[0][2], s);
            q.z = part_over_root(m[0][1] - m[1][0], s);
         end
         PICK_X: begin
            q.w = part_over_root(m[1][2] - m[2][1], s);
            q.x = clamp(big);
            q.y = part_over_root(m[0][1] + m[1][0], s);
            q.z = part_over_root(m[2][0] + m[0][2], s);
         end
         PICK_Y: begin
            q.w = part_over_root(m[2][0] - m[0][2], s);
            q.x = part_over_root(m[0][1] + m[1][0], s);
            q.y = clamp(big);
            q.z = part_over_root(m[1][2] + m[2][1], s);
         end
         default: begin
            q.w = part_over_root(m[0][1] - m[1][0], s);
            q.x = part_over_root(m[2][0] + m[0][2], s);
            q.y = part_over_root(m[1][2] + m[2][1], s);
            q.z = clamp(big);
         end
      endcase
      return q;
   endfunction

   function automatic matrix_type diag_mat(int a, int b, int c);
      matrix_type mt;
      foreach (mt.m[i]) mt.m[i] = '0;
      mt.m[0] = elem_type'(a);
      mt.m[4] = elem_type'(b);
      mt.m[8] = elem_type'(c);
      return mt;
   endfunction

   function automatic matrix_type fill_mat(int val);
      matrix_type mt;
      foreach (mt.m[i]) mt.m[i] = elem_type'(val);
      return mt;
   endfunction

   // proper rotation about a random axis, small noise on top
   function automatic matrix_type rotation_mat();
      matrix_type mt;
      real qw, qx, qy, qz, nrm, r [9];
      qw = $urandom_range(0, 2000) - 1000.0;
      qx = $urandom_range(0, 2000) - 1000.0;
      qy = $urandom_range(0, 2000) - 1000.0;
      qz = $urandom_range(0, 2000) - 1000.0;
      nrm = $sqrt(qw*qw + qx*qx + qy*qy + qz*qz) + 1e-9;
      qw /= nrm; qx /= nrm; qy /= nrm; qz /= nrm;
      r[0] = 1 - 2*(qy*qy + qz*qz); r[1] = 2*(qx*qy + qw*qz); r[2] = 2*(qx*qz - qw*qy);
      r[3] = 2*(qx*qy - qw*qz); r[4] = 1 - 2*(qx*qx + qz*qz); r[5] = 2*(qy*qz + qw*qx);
      r[6] = 2*(qx*qz + qw*qy); r[7] = 2*(qy*qz - qw*qx); r[8] = 1 - 2*(qx*qx + qy*qy);
      foreach (r[i])
         mt.m[i] = clamp(longint'($rtoi(r[i] * ONE)) + longint'($urandom_range(0, 8)) - 4);
      return mt;
   endfunction

   function automatic matrix_type noise_mat();
      matrix_type mt;
      foreach (mt.m[i]) mt.m[i] = elem_type'($urandom);
      return mt;
   endfunction

   function automatic quat_type make_q(int w, int x, int y, int z, pick_type p);
      quat_type q;
      q.w = elem_type'(w); q.x = elem_type'(x); q.y = elem_type'(y); q.z = elem_type'(z);
      q.pick = p;
      return q;
   endfunction

   task automatic add_row(matrix_type mt, bit fixed, quat_type q);
      row_type rw;
      rw.mat = mt; rw.fixed = fixed; rw.q = q;
      directed.push_back(rw);
   endtask

   task automatic build_table();
      quat_type none;
      matrix_type mt;
      none = make_q(0, 0, 0, 0, PICK_W);
      add_row(diag_mat(ONE, ONE, ONE), 1, make_q(ONE, 0, 0, 0, PICK_W));
      add_row(diag_mat(ONE, -ONE, -ONE), 1, make_q(0, ONE, 0, 0, PICK_X));
      add_row(diag_mat(-ONE, ONE, -ONE), 1, make_q(0, 0, ONE, 0, PICK_Y));
      add_row(diag_mat(-ONE, -ONE, ONE), 1, make_q(0, 0, 0, ONE, PICK_Z));
      // all zero: four-way tie goes to w
      add_row(diag_mat(0, 0, 0), 1, make_q(8192, 0, 0, 0, PICK_W));
      // x/y tie goes to x
      add_row(diag_mat(0, 0, -ONE), 0, none);
      add_row(diag_mat(-ONE, -ONE, -ONE), 0, none);
      add_row(fill_mat(32767), 0, none);
      add_row(fill_mat(-32768), 0, none);
      add_row(diag_mat(32767, 32767, 32767), 0, none);
      add_row(diag_mat(-32768, -32768, -32768), 0, none);
      add_row(diag_mat(32767, -32768, -32768), 0, none);
      add_row(diag_mat(-32768, 32767, -32768), 0, none);
      add_row(diag_mat(-32768, -32768, 32767), 0, none);
      // saturating off-diagonals with a small root
      mt = diag_mat(-32768, -32768, -32768);
      mt.m[1] = elem_type'(32767); mt.m[3] = elem_type'(-32768);
      mt.m[5] = elem_type'(32767); mt.m[7] = elem_type'(-32768);
      mt.m[2] = elem_type'(-32768); mt.m[6] = elem_type'(32767);
      add_row(mt, 0, none);
      mt.m[1] = elem_type'(-32768); mt.m[3] = elem_type'(32767);
      mt.m[5] = elem_type'(-32768); mt.m[7] = elem_type'(32767);
      add_row(mt, 0, none);
      for (int i = 0; i < 9; i++) begin
         mt = diag_mat(0, 0, 0);
         mt.m[i] = elem_type'((i % 2) ? -32768 : 32767);
         add_row(mt, 0, none);
      end
   endtask

   task automatic send(matrix_type mt, quat_type q);
      req_ch.valid     <= 1'b1;
      req_ch.col0_row0 <= mt.m[0];
      req_ch.col0_row1 <= mt.m[1];
      req_ch.col0_row2 <= mt.m[2];
      req_ch.col1_row0 <= mt.m[3];
      req_ch.col1_row1 <= mt.m[4];
      req_ch.col1_row2 <= mt.m[5];
      req_ch.col2_row0 <= mt.m[6];
      req_ch.col2_row1 <= mt.m[7];
      req_ch.col2_row2 <= mt.m[8];
      do @(posedge clock); while (!req_ch.ready);
      quat_pending.push_back(q);
      n_sent++;
   endtask

   task automatic gap();
      int n;
      n = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // sender
   initial begin
      matrix_type mt;
      int sel;
      req_ch.valid <= 1'b0;
      {req_ch.col0_row0, req_ch.col0_row1, req_ch.col0_row2, req_ch.col1_row0,
       req_ch.col1_row1, req_ch.col1_row2, req_ch.col2_row0, req_ch.col2_row1,
       req_ch.col2_row2} <= '0;
      build_table();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         send(directed[i].mat,
              directed[i].fixed ? directed[i].q : shepperd(directed[i].mat));
         gap();
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 2) begin
            // hold until the pipeline has drained completely
            req_ch.valid <= 1'b0;
            while (quat_pending.size() != 0) @(posedge clock);
         end
         sel = $urandom_range(0, 9);
         mt = (sel < 7) ? rotation_mat() : noise_mat();
         send(mt, shepperd(mt));
         gap();
      end
      req_ch.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // result side: random stall, check each beat
   initial begin
      quat_type exp_q;
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (quat_pending.size() == 0) begin
               $error("unexpected quaternion beat");
               n_fail++;
            end else begin
               exp_q = quat_pending.pop_front();
               n_recv++;
               pick_seen[exp_q.pick]++;
               if (rsp_ch.quat_w !== exp_q.w) begin
                  $error("quat_w: expected %0d got %0d", exp_q.w, rsp_ch.quat_w);
                  n_fail++;
               end
               if (rsp_ch.quat_x !== exp_q.x) begin
                  $error("quat_x: expected %0d got %0d", exp_q.x, rsp_ch.quat_x);
                  n_fail++;
               end
               if (rsp_ch.quat_y !== exp_q.y) begin
                  $error("quat_y: expected %0d got %0d", exp_q.y, rsp_ch.quat_y);
                  n_fail++;
               end
               if (rsp_ch.quat_z !== exp_q.z) begin
                  $error("quat_z: expected %0d got %0d", exp_q.z, rsp_ch.quat_z);
                  n_fail++;
               end
               if (rsp_ch.largest_pick !== exp_q.pick) begin
                  $error("largest_pick: expected %0d got %0d", exp_q.pick,
                         rsp_ch.largest_pick);
                  n_fail++;
               end
            end
         end
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            // hold off the output for the rest of a long stall
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if ((n_recv / 300) % 2 == 1) begin
            rsp_ch.ready <= 1'b1;   // stretch with no stalling
         end else if ($urandom_range(0, 199) == 0) begin
            stall_left = $urandom_range(10, 60);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 19) == 0) ? 1'b0 :
                            ($urandom_range(0, 9) < 7);
         end
      end
   end

   // watchdog and end of run
   initial begin
      int tail;
      tail = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("timeout: %0d matrices outstanding", quat_pending.size());
            $display("*** FAILED ***");
            $finish;
         end
         if (stim_done && quat_pending.size() == 0) begin
            tail++;
            if (tail >= DRAIN) begin
               $display("Sent %0d matrices, checked %0d quaternions", n_sent, n_recv);
               $display("Picks w/x/y/z: %0d/%0d/%0d/%0d", pick_seen[0], pick_seen[1],
                        pick_seen[2], pick_seen[3]);
               if (n_fail == 0)
                  $display("*** PASSED ***");
               else
                  $display("*** FAILED ***");
               $finish;
            end
         end
      end
   end

endmodule

// ===== filelist.f =====
rtl/rmq_pkg.sv
rtl/rmq_if.sv
rtl/rmq_div_lane.sv
rtl/rotation_matrix_to_quaternion_core.sv
tb/tb_rotation_matrix_to_quaternion_core.sv
